// ===== src/keyed_presence_table_top_assert.svh =====
// Assertion macros for the keyed presence table.
// KPT_ASSERT checks a property at every rising clock edge outside reset.
// KPT_ASSERT_NEXT checks that a condition leads to another one in the next cycle.
`ifndef KEYED_PRESENCE_TABLE_TOP_ASSERT_SVH
`define KEYED_PRESENCE_TABLE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define KPT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("keyed presence table check failed");
`define KPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyed presence table check failed");
`else
`define KPT_ASSERT(lbl, clk, rst_n, prop)
`define KPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/kpt_pkg.sv =====
package kpt_pkg;

  localparam int unsigned TableDepth = 128;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned KeyW       = 32;
  localparam int unsigned StoreW     = 31;
  localparam int unsigned SlotW      = 7;
  localparam int unsigned CountW     = 8;

  typedef enum logic [1:0] {
    CmdAdd    = 2'd0,
    CmdSearch = 2'd1,
    CmdDelete = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StNotFound  = 3'd1,
    StFull      = 3'd2,
    StInvalid   = 3'd3,
    StDuplicate = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    StateIdle  = 3'b001,
    StateScan  = 3'b010,
    StateDrain = 3'b100
  } state_e;

  // Query token that walks down the chain, one cell per cycle.
  typedef struct packed {
    logic              active;
    logic              key_sign;
    logic [StoreW-1:0] key;
    logic              found;
    logic [IdxW-1:0]   match_idx;
    logic              free_found;
    logic [IdxW-1:0]   free_idx;
  } token_t;

  // Write command broadcast to all cells; each cell decodes its own index.
  typedef struct packed {
    logic              set;
    logic              clr;
    logic [IdxW-1:0]   idx;
    logic [StoreW-1:0] key;
  } wr_t;

endpackage

// ===== src/kpt_cell.sv =====
module kpt_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [kpt_pkg::IdxW-1:0]      idx_i,
  input  kpt_pkg::wr_t                  wr_i,
  input  kpt_pkg::token_t               tok_i,
  output kpt_pkg::token_t               tok_o
);

  logic                       valid_q;
  logic [kpt_pkg::StoreW-1:0] key_q;
  logic                       act_q;
  kpt_pkg::token_t            tok_d;
  kpt_pkg::token_t            tok_q;
  logic                       hit;
  logic                       wr_sel;

  assign wr_sel = (wr_i.idx == idx_i);
  assign hit    = valid_q && !tok_i.key_sign && (key_q == tok_i.key);

  // The first matching and the first free cell seen along the way win.
  always_comb begin
    tok_d = tok_i;
    if (!tok_i.found && hit) begin
      tok_d.found     = 1'b1;
      tok_d.match_idx = idx_i;
    end
    if (!tok_i.free_found && !valid_q) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      act_q   <= 1'b0;
    end else begin
      act_q <= tok_i.active;
      if (wr_i.set && wr_sel) begin
        valid_q <= 1'b1;
      end else if (wr_i.clr && wr_sel) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (wr_i.set && wr_sel) begin
      key_q <= wr_i.key;
    end
  end

  always_comb begin
    tok_o        = tok_q;
    tok_o.active = act_q;
  end

endmodule

// ===== src/kpt_ctrl.sv =====
module kpt_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic signed [kpt_pkg::KeyW-1:0] book_key_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [kpt_pkg::SlotW-1:0]     slot_index_o,
  output logic [kpt_pkg::CountW-1:0]    entry_count_o,
  output kpt_pkg::token_t               head_o,
  input  kpt_pkg::token_t               tail_i,
  output kpt_pkg::wr_t                  wr_o
);

  kpt_pkg::state_e            state_q, state_d;
  kpt_pkg::cmd_e              cmd_q;
  logic                       key_pos_q;
  logic [kpt_pkg::CntW-1:0]   count_q, count_d;
  logic                       head_act_q;
  kpt_pkg::token_t            head_q;
  kpt_pkg::token_t            head_d;
  kpt_pkg::status_e           res_status_q, res_status_d;
  logic [kpt_pkg::SlotW-1:0]  res_slot_q, res_slot_d;
  logic [kpt_pkg::CountW-1:0] res_count_q;
  kpt_pkg::status_e           out_status_q;
  logic [kpt_pkg::SlotW-1:0]  out_slot_q;
  logic [kpt_pkg::CountW-1:0] out_count_q;
  logic                       out_valid_q;
  logic                       accept;
  logic                       tail_done;
  logic                       load_out;
  kpt_pkg::wr_t               wr_d;

  assign in_ready_o = (state_q == kpt_pkg::StateIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign tail_done  = (state_q == kpt_pkg::StateScan) && tail_i.active;
  assign load_out   = (state_q == kpt_pkg::StateDrain) && (!out_valid_q || out_ready_i);

  // Decide the result once the token has passed every cell.
  always_comb begin
    res_status_d = kpt_pkg::StNotFound;
    res_slot_d   = '0;
    count_d      = count_q;
    wr_d         = '0;
    wr_d.key     = tail_i.key;
    case (cmd_q)
      kpt_pkg::CmdAdd: begin
        if (count_q >= kpt_pkg::CntW'(kpt_pkg::TableDepth)) begin
          res_status_d = kpt_pkg::StFull;
        end else if (!key_pos_q) begin
          res_status_d = kpt_pkg::StInvalid;
        end else if (tail_i.found) begin
          res_status_d = kpt_pkg::StDuplicate;
        end else if (!tail_i.free_found) begin
          res_status_d = kpt_pkg::StFull;
        end else begin
          res_status_d = kpt_pkg::StOk;
          res_slot_d   = kpt_pkg::SlotW'(tail_i.free_idx);
          wr_d.set     = 1'b1;
          wr_d.idx     = tail_i.free_idx;
          count_d      = count_q + kpt_pkg::CntW'(1);
        end
      end
      kpt_pkg::CmdSearch: begin
        if (tail_i.found) begin
          res_status_d = kpt_pkg::StOk;
          res_slot_d   = kpt_pkg::SlotW'(tail_i.match_idx);
        end
      end
      kpt_pkg::CmdDelete: begin
        if (tail_i.found) begin
          res_status_d = kpt_pkg::StOk;
          res_slot_d   = kpt_pkg::SlotW'(tail_i.match_idx);
          wr_d.clr     = 1'b1;
          wr_d.idx     = tail_i.match_idx;
          if (count_q != '0) begin
            count_d = count_q - kpt_pkg::CntW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    wr_o     = wr_d;
    wr_o.set = wr_d.set && tail_done;
    wr_o.clr = wr_d.clr && tail_done;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      kpt_pkg::StateIdle: begin
        if (accept) begin
          state_d = kpt_pkg::StateScan;
        end
      end
      kpt_pkg::StateScan: begin
        if (tail_i.active) begin
          state_d = kpt_pkg::StateDrain;
        end
      end
      kpt_pkg::StateDrain: begin
        if (load_out) begin
          state_d = kpt_pkg::StateIdle;
        end
      end
      default: begin
        state_d = kpt_pkg::StateIdle;
      end
    endcase
  end

  always_comb begin
    head_d          = '0;
    head_d.key_sign = book_key_i[kpt_pkg::KeyW-1];
    head_d.key      = book_key_i[kpt_pkg::StoreW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kpt_pkg::StateIdle;
      count_q     <= '0;
      head_act_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_act_q <= accept;
      if (tail_done) begin
        count_q <= count_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= kpt_pkg::cmd_e'(cmd_i);
      key_pos_q <= (book_key_i != '0) && !book_key_i[kpt_pkg::KeyW-1];
      head_q    <= head_d;
    end
    if (tail_done) begin
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_count_q  <= kpt_pkg::CountW'(count_d);
    end
    if (load_out) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_count_q  <= res_count_q;
    end
  end

  always_comb begin
    head_o        = head_q;
    head_o.active = head_act_q;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_index_o  = out_slot_q;
  assign entry_count_o = out_count_q;

endmodule

// ===== src/keyed_presence_table_top.sv =====
// Keyed presence table: one command word in, one result word out.
// Commands are taken one at a time: a new command is accepted only once the
// result of the last one has moved to the output register. The query token
// steps through the cell chain one cell per clock.
// Reset clears the valid marks, the entry count and all control state at once,
// with no clearing pass; stored keys are not reset.
`include "keyed_presence_table_top_assert.svh"

module keyed_presence_table_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      cmd_i,
  input  logic signed [kpt_pkg::KeyW-1:0] book_key_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      status_o,
  output logic [kpt_pkg::SlotW-1:0]       slot_index_o,
  output logic [kpt_pkg::CountW-1:0]      entry_count_o
);

  // The table is a row of identical cells. Each cell keeps one key and its
  // valid mark. A command word enters the controller, which launches a query
  // token into the first cell. Every cycle the token moves one cell down the
  // row; each cell compares the query key with its own entry and records the
  // first match and the first free slot that the token has met so far.
  // Because the token visits cells in index order, the first hit it records
  // is the lowest matching slot, and likewise for the lowest free slot.

  kpt_pkg::token_t tok [kpt_pkg::TableDepth+1];
  kpt_pkg::wr_t    wr;
  logic [kpt_pkg::TableDepth:0] act_vec;

  // When the token leaves the last cell, the controller settles the status,
  // broadcasts at most one write (set on a successful add, clear on a
  // successful delete) that the addressed cell picks up, and moves the result
  // to the output register, which holds a finished word while the chain sits idle.
  kpt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .book_key_i    (book_key_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .slot_index_o  (slot_index_o),
    .entry_count_o (entry_count_o),
    .head_o        (tok[0]),
    .tail_i        (tok[kpt_pkg::TableDepth]),
    .wr_o          (wr)
  );

  assign act_vec[0] = tok[0].active;

  for (genvar i = 0; i < kpt_pkg::TableDepth; i++) begin : g_cell
    kpt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (kpt_pkg::IdxW'(i)),
      .wr_i   (wr),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
    assign act_vec[i+1] = tok[i+1].active;
  end

  // Only one command is in flight, so at most one token is live in the row.
  `KPT_ASSERT(a_single_token, clk_i, rst_ni, $countones(act_vec) <= 1)
  // An accepted command launches its token in the next cycle.
  `KPT_ASSERT_NEXT(a_launch, clk_i, rst_ni, in_valid_i && in_ready_o, tok[0].active)
  // No new command is taken while a token reaches the end of the row.
  `KPT_ASSERT(a_no_accept_at_tail, clk_i, rst_ni,
              !tok[kpt_pkg::TableDepth].active || !in_ready_o)
  // A failed command always reports slot zero.
  `KPT_ASSERT(a_fail_slot_zero, clk_i, rst_ni,
              !out_valid_o || (status_o == kpt_pkg::StOk) || (slot_index_o == '0))

endmodule

// ===== sim/tb_keyed_presence_table_top.sv =====
module tb_keyed_presence_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kpt_pkg::*;

  // The command code that the block leaves undefined. It must answer
  // "not found" and leave the table alone.
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam int unsigned ResetCycles = 11;
  localparam int unsigned TotalItems  = 1800;
  localparam int unsigned BlockItems  = 150;   // items per stimulus mix block
  localparam int unsigned HoldStart   = 20000; // cycle at which the long stall begins
  localparam int unsigned LongHold    = 2000;  // length of the long output stall
  localparam int unsigned MaxReports  = 30;

  // One result word as the block reports it.
  typedef struct packed {
    status_e             status;
    logic [SlotW-1:0]    slot;
    logic [CountW-1:0]   count;
  } answer_t;

  // One row of the directed table. Where "typed" is set, the answer is
  // written out by hand; otherwise the predictor supplies it.
  typedef struct {
    logic [1:0]  op;
    logic [31:0] key;
    bit          typed;
    answer_t     ans;
  } vector_t;

  // Command mix of a block of random items.
  typedef enum {MixFill, MixBalanced, MixDrain} mix_e;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               cmd_i        = 2'd0;
  logic signed [KeyW-1:0]   book_key_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i  = 1'b0;
  logic [2:0]               status_o;
  logic [SlotW-1:0]         slot_index_o;
  logic [CountW-1:0]        entry_count_o;

  keyed_presence_table_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .book_key_i    (book_key_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .slot_index_o  (slot_index_o),
    .entry_count_o (entry_count_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the table. Keys are only ever read where the slot is
  // marked, so the unwritten entries never matter.
  logic [StoreW-1:0] keys_held [TableDepth];
  bit                marks     [TableDepth];
  int unsigned       held_count;

  // Answers still owed by the block, oldest first.
  answer_t expected_answers [$];

  int unsigned error_count;
  int unsigned ops_issued  [4];
  int unsigned status_seen [8];
  int unsigned peak_count;
  bit          quiet_tail;   // set for the final stretch: no idling on either side

  // Directed part. The first rows start from an empty table, so their
  // answers can be written down directly: reset state, non-positive keys,
  // the two key extremes, a duplicate add, a negative key whose low bits
  // equal a stored key, and the unused command code. The later rows reuse
  // freed slots and are left to the predictor.
  vector_t directed_rows [24] = '{
    '{CmdSearch, 32'h0000_0005, 1'b1, '{StNotFound,  7'd0, 8'd0}},
    '{CmdDelete, 32'h0000_0005, 1'b1, '{StNotFound,  7'd0, 8'd0}},
    '{CmdAdd,    32'h0000_0000, 1'b1, '{StInvalid,   7'd0, 8'd0}},
    '{CmdAdd,    32'hFFFF_FFFF, 1'b1, '{StInvalid,   7'd0, 8'd0}},
    '{CmdAdd,    32'h8000_0000, 1'b1, '{StInvalid,   7'd0, 8'd0}},
    '{CmdAdd,    32'h0000_0001, 1'b1, '{StOk,        7'd0, 8'd1}},
    '{CmdAdd,    32'h7FFF_FFFF, 1'b1, '{StOk,        7'd1, 8'd2}},
    '{CmdAdd,    32'h0000_0001, 1'b1, '{StDuplicate, 7'd0, 8'd2}},
    '{CmdSearch, 32'h7FFF_FFFF, 1'b1, '{StOk,        7'd1, 8'd2}},
    '{CmdSearch, 32'hFFFF_FFFF, 1'b1, '{StNotFound,  7'd0, 8'd2}},
    '{CmdSearch, 32'h0000_0000, 1'b1, '{StNotFound,  7'd0, 8'd2}},
    '{CmdUnused, 32'h0000_0001, 1'b1, '{StNotFound,  7'd0, 8'd2}},
    '{CmdUnused, 32'h7FFF_FFFF, 1'b1, '{StNotFound,  7'd0, 8'd2}},
    '{CmdDelete, 32'h0000_0001, 1'b1, '{StOk,        7'd0, 8'd1}},
    '{CmdDelete, 32'h0000_0001, 1'b1, '{StNotFound,  7'd0, 8'd1}},
    '{CmdDelete, 32'hFFFF_FFFF, 1'b1, '{StNotFound,  7'd0, 8'd1}},
    '{CmdAdd,    32'h2AAA_AAAA, 1'b0, '{StOk,        7'd0, 8'd0}},
    '{CmdAdd,    32'h5555_5555, 1'b0, '{StOk,        7'd0, 8'd0}},
    '{CmdSearch, 32'h5555_5555, 1'b0, '{StOk,        7'd0, 8'd0}},
    '{CmdDelete, 32'h7FFF_FFFF, 1'b0, '{StOk,        7'd0, 8'd0}},
    '{CmdAdd,    32'h7FFF_FFFF, 1'b0, '{StOk,        7'd0, 8'd0}},
    '{CmdSearch, 32'h2AAA_AAAA, 1'b0, '{StOk,        7'd0, 8'd0}},
    '{CmdDelete, 32'h5555_5555, 1'b0, '{StOk,        7'd0, 8'd0}},
    '{CmdAdd,    32'h5555_5555, 1'b0, '{StOk,        7'd0, 8'd0}}
  };

  // Applies one command to the shadow table and returns the answer the
  // block should give. A key can only match when its sign bit is clear,
  // since every stored key is positive.
  function automatic answer_t apply_command(logic [1:0] op, logic [31:0] key);
    answer_t a;
    int      hit;
    int      spare;
    bit      positive;
    a        = '{StNotFound, '0, '0};
    hit      = -1;
    spare    = -1;
    positive = (key != 32'd0) && !key[31];
    // Walking down keeps the lowest matching and lowest free slot.
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (marks[i] && !key[31] && keys_held[i] == key[StoreW-1:0]) hit = i;
      if (!marks[i]) spare = i;
    end
    if (op == CmdAdd) begin
      // The order of these checks is part of the behavior.
      if (held_count >= TableDepth) a.status = StFull;
      else if (!positive) a.status = StInvalid;
      else if (hit >= 0) a.status = StDuplicate;
      else if (spare < 0) a.status = StFull;
      else begin
        keys_held[spare] = key[StoreW-1:0];
        marks[spare]     = 1'b1;
        held_count++;
        a.status = StOk;
        a.slot   = spare[SlotW-1:0];
      end
    end else if ((op == CmdSearch || op == CmdDelete) && hit >= 0) begin
      if (op == CmdDelete) begin
        marks[hit] = 1'b0;
        if (held_count > 0) held_count--;
      end
      a.status = StOk;
      a.slot   = hit[SlotW-1:0];
    end
    a.count = held_count[CountW-1:0];
    return a;
  endfunction

  // Some key that is in the table right now, starting the search at a
  // random slot so that every slot gets picked. An empty table yields a
  // fresh key with its sign bit clear instead.
  function automatic logic [31:0] live_key();
    int unsigned start;
    start = $urandom_range(0, TableDepth - 1);
    for (int i = 0; i < TableDepth; i++) begin
      if (marks[(start + i) % TableDepth]) return {1'b0, keys_held[(start + i) % TableDepth]};
    end
    return $urandom() & 32'h7FFF_FFFF;
  endfunction

  // Offers one command word and waits for the block to take it. Called at a
  // rising edge; returns at the edge of acceptance without touching valid,
  // so a following word keeps valid high with no drop in between.
  task automatic offer_word(input logic [1:0] op, input logic [31:0] key,
                            input bit typed, input answer_t typed_ans);
    answer_t predicted;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    book_key_i <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // The predictor always runs so that its table tracks the block, even
    // where the answer for this word was written out by hand.
    predicted = apply_command(op, key);
    expected_answers.push_back(typed ? typed_ans : predicted);
    ops_issued[op]++;
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    error_count++;
    if (error_count <= MaxReports)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
  endtask

  // Result checker. Every accepted result word is matched against the
  // oldest answer still owed, field by field.
  always @(posedge clk_i) begin : result_check
    answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_answers.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("%0t ns: result word with none expected, expected nothing, got %0d/%0d/%0d",
                   $time, status_o, slot_index_o, entry_count_o);
      end else begin
        want = expected_answers.pop_front();
        if (status_o != want.status) report_field("status", want.status, status_o);
        if (slot_index_o != want.slot) report_field("slot_index", want.slot, slot_index_o);
        if (entry_count_o != want.count) report_field("entry_count", want.count, entry_count_o);
      end
      status_seen[status_o]++;
      if (entry_count_o > peak_count) peak_count = entry_count_o;
    end
  end

  // Output side pacing. Ready toggles in random runs; once, well into the
  // run, it stays low for a long stretch so that the block backs up and
  // holds its input off while commands keep being offered. The stretch is
  // timed here by counting the cycles this process has waited.
  initial begin : result_pacing
    int unsigned run;
    int unsigned elapsed;
    bit          held;
    elapsed = 0;
    held    = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && elapsed >= HoldStart) begin
        held        = 1'b1;
        run         = LongHold;
        out_ready_i <= 1'b0;
      end else if (quiet_tail) begin
        run         = 1;
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        run         = $urandom_range(1, 15);
        out_ready_i <= 1'b0;
      end else begin
        run         = $urandom_range(1, 40);
        out_ready_i <= 1'b1;
      end
      repeat (run) @(posedge clk_i);
      elapsed += run;
    end
  end

  // Command feed: reset, the directed table, then random blocks.
  initial begin : command_feed
    mix_e        mix;
    int unsigned r;
    int unsigned random_items;
    logic [1:0]  op;
    logic [31:0] key;
    answer_t     none;
    none         = '{StOk, '0, '0};
    random_items = TotalItems - $size(directed_rows);
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer_word(directed_rows[i].op, directed_rows[i].key,
                 directed_rows[i].typed, directed_rows[i].ans);

    // The random part runs in blocks with different command mixes: fill
    // blocks drive the table to full and keep adding there, drain blocks
    // empty it and keep deleting on an empty table, and balanced blocks
    // churn slots in the middle.
    for (int unsigned n = 0; n < random_items; n++) begin
      case ((n / BlockItems) % 6)
        0, 1, 3: mix = MixFill;
        2:       mix = MixBalanced;
        default: mix = MixDrain;
      endcase
      if (n + BlockItems >= random_items) quiet_tail = 1'b1;

      r = $urandom_range(0, 99);
      case (mix)
        MixFill:     op = (r < 75) ? CmdAdd : (r < 90) ? CmdSearch :
                          (r < 98) ? CmdDelete : CmdUnused;
        MixBalanced: op = (r < 35) ? CmdAdd : (r < 68) ? CmdSearch :
                          (r < 98) ? CmdDelete : CmdUnused;
        default:     op = (r < 10) ? CmdAdd : (r < 35) ? CmdSearch :
                          (r < 97) ? CmdDelete : CmdUnused;
      endcase

      r = $urandom_range(0, 99);
      if (op == CmdAdd) begin
        // Mostly fresh keys; some repeats of live keys for the duplicate
        // check, some non-positive keys, and some keys at the extremes.
        if (r < 60) key = $urandom() & 32'h7FFF_FFFF;
        else if (r < 75) key = live_key();
        else if (r < 85) begin
          case ($urandom_range(0, 2))
            0:       key = 32'h0000_0000;
            1:       key = 32'h8000_0000;
            default: key = $urandom() | 32'h8000_0000;
          endcase
        end else begin
          case ($urandom_range(0, 2))
            0:       key = 32'h0000_0001;
            1:       key = 32'h7FFF_FFFF;
            default: key = 32'h1 << $urandom_range(0, 30);
          endcase
        end
      end else begin
        // Lookups mostly hit. A live key with its sign bit set must miss.
        if (r < 70) key = live_key();
        else if (r < 80) key = live_key() | 32'h8000_0000;
        else if (r < 95) key = $urandom();
        else key = 32'h0000_0000;
      end
      offer_word(op, key, 1'b0, none);
    end
    in_valid_i <= 1'b0;

    // Let every owed answer arrive, then give the block one more full
    // latency to show any stray result word.
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (TableDepth + 8) @(posedge clk_i);

    $display("Ran %0d commands: %0d add, %0d search, %0d delete, %0d unused code.",
             TotalItems, ops_issued[CmdAdd], ops_issued[CmdSearch],
             ops_issued[CmdDelete], ops_issued[CmdUnused]);
    $display("Answers: %0d ok, %0d not found, %0d full, %0d invalid, %0d duplicate; peak %0d.",
             status_seen[StOk], status_seen[StNotFound], status_seen[StFull],
             status_seen[StInvalid], status_seen[StDuplicate], peak_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog. A correct run needs about an eighth of this.
  initial begin : watchdog
    #40_000_000;
    $display("Timed out with %0d answers still owed.", expected_answers.size());
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/kpt_pkg.sv
src/kpt_cell.sv
src/kpt_ctrl.sv
src/keyed_presence_table_top.sv
sim/tb_keyed_presence_table_top.sv
